/* rtl/c2p_pkg.sv */
// Shared constants, types and helpers for the chunky-to-planar VRAM writer.
package c2p_pkg;

   // Frame and table geometry
   localparam int FRAME_WIDTH    = 320;
   localparam int FRAME_HEIGHT   = 200;
   localparam int PALETTE_COUNT  = 14;
   localparam int TABLE_DEPTH    = PALETTE_COUNT * 256;
   localparam int TABLE_AW       = $clog2(TABLE_DEPTH);
   localparam int GROUPS_PER_ROW = FRAME_WIDTH / 8;
   localparam int COL_W          = (GROUPS_PER_ROW > 1) ? $clog2(GROUPS_PER_ROW) : 1;
   localparam int ROW_QUADS      = (FRAME_HEIGHT + 3) / 4;
   localparam int RQ_W           = (ROW_QUADS > 1) ? $clog2(ROW_QUADS) : 1;
   localparam int LAST_COL       = GROUPS_PER_ROW - 1;
   localparam int LAST_RQ        = (FRAME_HEIGHT - 1) / 4;
   localparam int LAST_RM        = (FRAME_HEIGHT - 1) % 4;

   // Interleaved address: pitch * (row/4 + 18) + column + 25 + bank * row%4
   localparam int ROW_PITCH      = 90;
   localparam int BASE_OFFSET    = ROW_PITCH * 18 + 25;
   localparam int BANK_SHIFT     = 13;
   localparam int SUM_W          = 17;

   // Field widths
   localparam int VRAM_AW        = 15;
   localparam int PAL_W          = 4;
   localparam int PIX_W          = 8;
   localparam int COLOR_W        = 4;
   localparam int IDX_W          = 12;
   localparam int REQ_DATA_W     = 24;
   localparam int RSP_DATA_W     = 24;

   // Input kinds and plane codes
   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_PIXEL = 1'b1;
   localparam logic [1:0] PLANE_FIRST = 2'd0;
   localparam logic [1:0] PLANE_LAST  = 2'd3;
   localparam logic [2:0] SLOT_LAST   = 3'd7;

   // Group queue
   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = $clog2(Q_DEPTH);
   localparam int Q_CW    = $clog2(Q_DEPTH + 1);

   typedef logic [7:0][COLOR_W-1:0] colors_type;

   typedef struct packed {
      colors_type              colors;
      logic [VRAM_AW-1:0]      vram_address;
   } group_type;

   typedef struct packed {
      logic            valid;
      logic [Q_CW-1:0] count;
   } q_status_type;

   // One plane of a group: pixel k lands in bit 7-k
   function automatic logic [7:0] plane_bits(colors_type c, logic [1:0] p);
      logic [7:0] b;
      b = '0;
      for (int k = 0; k < 8; k++) begin
         b[3'(7 - k)] = c[k][p];
      end
      return b;
   endfunction

endpackage

/* rtl/c2p_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module c2p_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/c2p_front.sv */
// Front end: accepts words, loads the color table, looks up pixels and gathers groups.
module c2p_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [c2p_pkg::REQ_DATA_W-1:0]        req_tdata,
   input  logic                                  req_tuser,
   input  logic                                  csr_wr_en,
   input  logic [c2p_pkg::PAL_W-1:0]             csr_wr_data,
   input  c2p_pkg::q_status_type                 q_status,
   output logic                                  q_push,
   output c2p_pkg::group_type                    q_push_data
);

   // Input fields
   logic [c2p_pkg::IDX_W-1:0]   tbl_idx;
   logic [c2p_pkg::COLOR_W-1:0] tbl_color;
   logic [c2p_pkg::PIX_W-1:0]   pix;
   logic                        accept, load_en, pix_en, grp_done;

   // Registers
   logic [c2p_pkg::PAL_W-1:0]   pal_ff, pal_in;
   logic [2:0]                  slot_ff, slot_in;
   logic [c2p_pkg::COL_W-1:0]   col_ff, col_in;
   logic [c2p_pkg::RQ_W-1:0]    rq_ff, rq_in;
   logic [1:0]                  rm_ff, rm_in;
   logic                        s1_valid_ff, s1_valid_in;
   logic                        s1_last_ff, s1_last_in;
   logic                        s1_zero_ff, s1_zero_in;
   logic [2:0]                  s1_slot_ff, s1_slot_in;
   logic [c2p_pkg::VRAM_AW-1:0] s1_addr_ff, s1_addr_in;
   logic [6:0][c2p_pkg::COLOR_W-1:0] colors_ff, colors_in;

   logic [c2p_pkg::TABLE_AW-1:0] rd_addr;
   logic [c2p_pkg::COLOR_W-1:0]  rd_data, color;
   logic [c2p_pkg::SUM_W-1:0]    addr_sum;
   logic                         pending;

   assign tbl_idx   = req_tdata[11:0];
   assign tbl_color = req_tdata[15:12];
   assign pix       = req_tdata[23:16];

   // Room in the queue for every group that may still land there
   assign pending    = s1_valid_ff && s1_last_ff;
   assign req_tready = (32'(q_status.count) + 32'(pending)) < 32'(c2p_pkg::Q_DEPTH);

   assign accept   = req_tvalid && req_tready;
   assign load_en  = accept && (req_tuser == c2p_pkg::FUNC_LOAD)
                     && (32'(tbl_idx) < 32'(c2p_pkg::TABLE_DEPTH));
   assign pix_en   = accept && (req_tuser == c2p_pkg::FUNC_PIXEL);
   assign grp_done = pix_en && (slot_ff == c2p_pkg::SLOT_LAST);

   assign rd_addr = c2p_pkg::TABLE_AW'(32'(pal_ff) * 256 + 32'(pix));

   c2p_ram #(
      .WIDTH (c2p_pkg::COLOR_W),
      .DEPTH (c2p_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (load_en),
      .wr_addr (tbl_idx[c2p_pkg::TABLE_AW-1:0]),
      .wr_data (tbl_color),
      .rd_en   (pix_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Address of the current group
   assign addr_sum = c2p_pkg::SUM_W'(c2p_pkg::ROW_PITCH) * c2p_pkg::SUM_W'(rq_ff)
                   + c2p_pkg::SUM_W'(c2p_pkg::BASE_OFFSET)
                   + c2p_pkg::SUM_W'(col_ff)
                   + c2p_pkg::SUM_W'({rm_ff, {c2p_pkg::BANK_SHIFT{1'b0}}});

   // Pixel slot and frame position
   always_comb begin
      pal_in = csr_wr_en ? csr_wr_data : pal_ff;
      slot_in = slot_ff;
      col_in  = col_ff;
      rq_in   = rq_ff;
      rm_in   = rm_ff;
      if (pix_en) begin
         slot_in = 3'(slot_ff + 3'd1);
      end
      if (grp_done) begin
         if (32'(col_ff) == c2p_pkg::LAST_COL) begin
            col_in = '0;
            if ((32'(rq_ff) == c2p_pkg::LAST_RQ) && (32'(rm_ff) == c2p_pkg::LAST_RM)) begin
               rq_in = '0;
               rm_in = '0;
            end else if (rm_ff == 2'd3) begin
               rm_in = '0;
               rq_in = c2p_pkg::RQ_W'(rq_ff + 1'b1);
            end else begin
               rm_in = 2'(rm_ff + 2'd1);
            end
         end else begin
            col_in = c2p_pkg::COL_W'(col_ff + 1'b1);
         end
      end
   end

   // Lookup stage control
   always_comb begin
      s1_valid_in = pix_en;
      s1_last_in  = grp_done;
      s1_slot_in  = slot_ff;
      s1_zero_in  = 32'(pal_ff) >= 32'(c2p_pkg::PALETTE_COUNT);
      s1_addr_in  = grp_done ? addr_sum[c2p_pkg::VRAM_AW-1:0] : s1_addr_ff;
   end

   // Gather stage: park colors, push the full group
   assign color  = s1_zero_ff ? '0 : rd_data;
   assign q_push = s1_valid_ff && s1_last_ff;

   always_comb begin
      colors_in = colors_ff;
      if (s1_valid_ff && !s1_last_ff) begin
         colors_in[s1_slot_ff] = color;
      end
      for (int k = 0; k < 7; k++) begin
         q_push_data.colors[k] = colors_ff[k];
      end
      q_push_data.colors[7]    = color;
      q_push_data.vram_address = s1_addr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pal_ff      <= '0;
         slot_ff     <= '0;
         col_ff      <= '0;
         rq_ff       <= '0;
         rm_ff       <= '0;
         s1_valid_ff <= 1'b0;
         s1_last_ff  <= 1'b0;
         colors_ff   <= '0;
      end else begin
         pal_ff      <= pal_in;
         slot_ff     <= slot_in;
         col_ff      <= col_in;
         rq_ff       <= rq_in;
         rm_ff       <= rm_in;
         s1_valid_ff <= s1_valid_in;
         s1_last_ff  <= s1_last_in;
         colors_ff   <= colors_in;
      end
      s1_slot_ff <= s1_slot_in;
      s1_zero_ff <= s1_zero_in;
      s1_addr_ff <= s1_addr_in;
   end

endmodule

/* rtl/c2p_queue.sv */
// Short queue of finished pixel groups between the front and back ends.
module c2p_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  c2p_pkg::group_type    push_data,
   input  logic                  pop,
   output c2p_pkg::group_type    head,
   output c2p_pkg::q_status_type status
);

   c2p_pkg::group_type           entry_ff [c2p_pkg::Q_DEPTH];
   logic [c2p_pkg::Q_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [c2p_pkg::Q_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [c2p_pkg::Q_CW-1:0]     count_ff, count_in;
   logic                         do_push, do_pop;

   assign do_pop  = pop && (count_ff != '0);
   assign do_push = push && ((32'(count_ff) < c2p_pkg::Q_DEPTH) || do_pop);

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = do_push ? c2p_pkg::Q_AW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? c2p_pkg::Q_AW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = c2p_pkg::Q_CW'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = c2p_pkg::Q_CW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head         = entry_ff[rd_ptr_ff];
   assign status.valid = count_ff != '0;
   assign status.count = count_ff;

endmodule

/* rtl/c2p_back.sv */
// Back end: turns each queued group into four plane writes behind an output register.
module c2p_back (
   input  logic                           clock,
   input  logic                           reset,
   input  c2p_pkg::group_type             q_head,
   input  c2p_pkg::q_status_type          q_status,
   output logic                           q_pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [c2p_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]                     rsp_tuser,
   output logic                           rsp_tlast
);

   logic [1:0]                  plane_ff, plane_in;
   logic                        valid_ff, valid_in;
   logic [1:0]                  sel_ff, sel_in;
   logic [c2p_pkg::VRAM_AW-1:0] addr_ff, addr_in;
   logic [7:0]                  byte_ff, byte_in;
   logic                        last_ff, last_in;
   logic                        load;

   // Output register takes a new word when empty or being drained
   assign load  = !valid_ff || rsp_tready;
   assign q_pop = load && q_status.valid && (plane_ff == c2p_pkg::PLANE_LAST);

   always_comb begin
      plane_in = plane_ff;
      valid_in = valid_ff;
      sel_in   = sel_ff;
      addr_in  = addr_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = q_status.valid;
         if (q_status.valid) begin
            sel_in   = plane_ff;
            addr_in  = q_head.vram_address;
            byte_in  = c2p_pkg::plane_bits(q_head.colors, plane_ff);
            last_in  = plane_ff == c2p_pkg::PLANE_LAST;
            plane_in = 2'(plane_ff + 2'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff <= c2p_pkg::PLANE_FIRST;
         valid_ff <= 1'b0;
      end else begin
         plane_ff <= plane_in;
         valid_ff <= valid_in;
      end
      sel_ff  <= sel_in;
      addr_ff <= addr_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {1'b0, byte_ff, addr_ff};
   assign rsp_tuser  = sel_ff;
   assign rsp_tlast  = last_ff;

endmodule

/* rtl/chunky_to_planar_vram_writer_top.sv */
// Top level of the chunky-to-planar VRAM writer.
//
// Input channel (req_): one word per cycle while req_tready is high. tuser
// selects the kind: a table load writes one 4-bit color into the palette
// table, a pixel word carries an 8-bit indexed pixel in raster order. Every
// eighth pixel completes a group, which comes out on the result channel (rsp_)
// as four plane writes, planes 0 to 3, each with its interleaved video memory
// address; tlast marks plane 3. csr_wr_en/csr_wr_data select the palette;
// write it only while idle.
// The first plane write of a group passes the lookup stage, the group queue
// and the output register; the other three follow one per cycle while
// rsp_tready is high. Throughput: one input word per cycle while req_tready
// is high; a group leaves the single output register as four plane writes.
// A four-group queue sits between the lookup and the plane output, so
// req_tready drops only once the receiver has stalled long enough to fill it.
// Reset clears the frame position, the pixel group and the palette select;
// the color table is not cleared and must be loaded before use.
module chunky_to_planar_vram_writer_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [11:0] table_index, [15:12] table_color, [23:16] pixel_value
   input  logic [c2p_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] func
   input  logic                           req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [14:0] vram_address, [22:15] plane_byte, [23] zero
   output logic [c2p_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [1:0] plane_select
   output logic [1:0]                     rsp_tuser,
   // last_of_group
   output logic                           rsp_tlast,
   input  logic                           csr_wr_en,
   input  logic [c2p_pkg::PAL_W-1:0]      csr_wr_data
);

   logic                  q_push, q_pop;
   c2p_pkg::group_type    q_push_data, q_head;
   c2p_pkg::q_status_type q_status;

   c2p_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   c2p_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .head      (q_head),
      .status    (q_status)
   );

   c2p_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_head     (q_head),
      .q_status   (q_status),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // A finished group always finds room in the queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> ((32'(q_status.count) < c2p_pkg::Q_DEPTH) || q_pop))
      else $error("group queue overflow");

   // tlast goes with the last plane only
   a_last_plane: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == c2p_pkg::PLANE_LAST)))
      else $error("tlast and plane select disagree");

   // Planes follow one another in order across taken words
   a_plane_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready) ##1 rsp_tvalid
         |-> (rsp_tuser == 2'($past(rsp_tuser) + 2'd1)))
      else $error("plane order broken");

   // Nothing leaves the queue while it is empty
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_status.valid)
      else $error("pop from empty queue");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the chunky-to-planar VRAM writer, with its plane-write scoreboard.
package c2p_tb_pkg;

   typedef struct packed {
      logic [1:0]                  plane_select;
      logic [c2p_pkg::VRAM_AW-1:0] vram_address;
      logic [7:0]                  plane_byte;
      logic                        last_of_group;
   } plane_write_type;

   // Tracks table, palette and frame position; predicts the four plane writes per group
   class c2p_scoreboard;
      logic [c2p_pkg::COLOR_W-1:0] color_table [c2p_pkg::TABLE_DEPTH];
      logic [c2p_pkg::PAL_W-1:0]   palette;
      logic [c2p_pkg::COLOR_W-1:0] group_colors [8];
      int                          slot;
      int                          column;
      int                          row;
      plane_write_type             pending_writes [$];
      int                          mismatches;

      function new();
         palette    = '0;
         slot       = 0;
         column     = 0;
         row        = 0;
         mismatches = 0;
         foreach (group_colors[k]) group_colors[k] = '0;
         foreach (color_table[i]) color_table[i] = '0;
      endfunction

      function void set_palette(logic [c2p_pkg::PAL_W-1:0] p);
         palette = p;
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch: %s", msg);
         end
      endfunction

      // One accepted input word: table load or pixel
      function void note_word(logic func, logic [c2p_pkg::IDX_W-1:0] idx,
                              logic [c2p_pkg::COLOR_W-1:0] color,
                              logic [c2p_pkg::PIX_W-1:0] pix);
         int unsigned     addr;
         plane_write_type w;
         if (func == c2p_pkg::FUNC_LOAD) begin
            // loads past the table are dropped
            if (int'(idx) < c2p_pkg::TABLE_DEPTH) color_table[idx] = color;
            return;
         end
         // palettes past the table read as black
         if (int'(palette) < c2p_pkg::PALETTE_COUNT) begin
            group_colors[slot] = color_table[int'(palette) * 256 + int'(pix)];
         end else begin
            group_colors[slot] = '0;
         end
         if (slot < 7) begin
            slot++;
            return;
         end
         // interleaved address: one 8K bank per row%4
         addr = 90 * (row / 4 + 18) + column + 25 + 32'h2000 * (row % 4);
         for (int p = 0; p < 4; p++) begin
            w.plane_select  = 2'(p);
            w.vram_address  = addr[c2p_pkg::VRAM_AW-1:0];
            for (int k = 0; k < 8; k++) begin
               w.plane_byte[7-k] = group_colors[k][p];
            end
            w.last_of_group = (2'(p) == c2p_pkg::PLANE_LAST);
            pending_writes.push_back(w);
         end
         slot = 0;
         column++;
         if (column >= c2p_pkg::GROUPS_PER_ROW) begin
            column = 0;
            row++;
            if (row >= c2p_pkg::FRAME_HEIGHT) row = 0;
         end
      endfunction

      // One accepted plane write against the oldest prediction
      function void check_write(logic [1:0] plane, logic [c2p_pkg::VRAM_AW-1:0] addr,
                                logic [7:0] bits, logic last);
         plane_write_type want;
         if (pending_writes.size() == 0) begin
            flag($sformatf("unexpected write plane %0d addr %h byte %h last %b",
                           plane, addr, bits, last));
            return;
         end
         want = pending_writes.pop_front();
         if (want.plane_select !== plane || want.vram_address !== addr ||
             want.plane_byte !== bits || want.last_of_group !== last) begin
            flag($sformatf("expected plane %0d addr %h byte %h last %b, got %0d %h %h %b",
                           want.plane_select, want.vram_address, want.plane_byte,
                           want.last_of_group, plane, addr, bits, last));
         end
      endfunction
   endclass
endpackage

module tb_top;

   logic                           clock       = 1'b0;
   logic                           reset       = 1'b1;
   logic                           req_tvalid  = 1'b0;
   logic                           req_tready;
   logic [c2p_pkg::REQ_DATA_W-1:0] req_tdata   = '0;
   logic                           req_tuser   = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready  = 1'b0;
   logic [c2p_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]                     rsp_tuser;
   logic                           rsp_tlast;
   logic                           csr_wr_en   = 1'b0;
   logic [c2p_pkg::PAL_W-1:0]      csr_wr_data = '0;

   c2p_tb_pkg::c2p_scoreboard sb;
   int            send_idle_pct = 22;
   int            rsp_idle_pct  = 68;
   int            cur_palette   = 0;
   bit            loaded [4096];

   chunky_to_planar_vram_writer_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #6 clock = ~clock;

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   // Monitor: register writes, accepted words, accepted plane writes
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en) sb.set_palette(csr_wr_data);
         if (req_tvalid && req_tready) begin
            sb.note_word(req_tuser, req_tdata[11:0], req_tdata[15:12], req_tdata[23:16]);
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_write(rsp_tuser, rsp_tdata[14:0], rsp_tdata[22:15], rsp_tlast);
         end
      end
   end

   // Present one word, with random gaps before it, and wait for the handshake
   task automatic send_word(logic func, logic [c2p_pkg::IDX_W-1:0] idx,
                            logic [c2p_pkg::COLOR_W-1:0] color,
                            logic [c2p_pkg::PIX_W-1:0] pix);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {pix, color, idx};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic load_entry(int idx, int color);
      send_word(c2p_pkg::FUNC_LOAD, 12'(idx), 4'(color), 8'($urandom_range(0, 255)));
      if (idx < c2p_pkg::TABLE_DEPTH) loaded[idx] = 1'b1;
   endtask

   // Never look up an entry that was not loaded: load it first
   task automatic send_pixel(int pix);
      int entry;
      entry = cur_palette * 256 + pix;
      if (cur_palette < c2p_pkg::PALETTE_COUNT && !loaded[entry]) begin
         load_entry(entry, $urandom_range(0, 15));
      end
      send_word(c2p_pkg::FUNC_PIXEL, 12'($urandom_range(0, 4095)),
                4'($urandom_range(0, 15)), 8'(pix));
   endtask

   task automatic random_item();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         load_entry($urandom_range(0, 4095), $urandom_range(0, 15));
      end else if (r < 25) begin
         load_entry(cur_palette * 256 + $urandom_range(0, 255), $urandom_range(0, 15));
      end else begin
         send_pixel($urandom_range(0, 255));
      end
   endtask

   // Drain all writes, let the pipeline settle, then switch palette
   task automatic select_palette(int p);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending_writes.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= 4'(p);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cur_palette = p;
   endtask

   // Timeout
   initial begin
      #(12 * 1000000);
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      select_palette(0);

      // directed: table extremes, out-of-range loads, one group each in palettes 0 and 13
      load_entry(0, 15);
      load_entry(255, 0);
      load_entry(170, 9);
      load_entry(85, 6);
      load_entry(3583, 15);
      load_entry(3328, 10);
      load_entry(3584, 15);
      load_entry(4095, 0);
      send_pixel(0);
      send_pixel(255);
      send_pixel(170);
      send_pixel(85);
      send_pixel(0);
      send_pixel(255);
      send_pixel(85);
      send_pixel(170);
      select_palette(13);
      send_pixel(255);
      send_pixel(0);
      send_pixel(255);
      send_pixel(0);
      send_pixel(255);
      send_pixel(255);
      send_pixel(0);
      send_pixel(0);

      // sender idles lightly, receiver heavily
      select_palette($urandom_range(1, 12));
      repeat (12) random_item();
      select_palette(15);
      repeat (10) random_item();

      // the other way round; palette 14 is past the table
      send_idle_pct = 68;
      rsp_idle_pct  = 22;
      select_palette(14);
      repeat (10) random_item();
      select_palette($urandom_range(0, 13));
      repeat (12) random_item();

      // no idling: groups back to back
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      select_palette(0);
      repeat (24) begin
         if ($urandom_range(0, 15) == 0) begin
            load_entry($urandom_range(0, 255), $urandom_range(0, 15));
         end
         send_pixel($urandom_range(0, 255));
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending_writes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_writes.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
